@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the core deframer module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define ACD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define ACD_ASSERT_IMP(lbl, ante, cons, msg) \
  `ACD_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ACD_ASSERT_NXT(lbl, ante, cons, msg) \
  `ACD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ rtl/core/acd_pkg.sv @@
`default_nettype none
package acd_pkg;

  localparam int HEADER_BITS = 32;
  localparam int LEN_BITS    = 16;
  localparam int CODE_W      = 64;
  localparam int LEN_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCESS_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_LENGTH = 2'd1;

  localparam logic [LEN_W-1:0] CODE_LEN_RESET = 7'd64;

endpackage
`default_nettype wire

@@ rtl/core/acd_cell.sv @@
`default_nettype none
// One history bit with a fill flag; compares against its code bit when cared.
module acd_cell (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic shift_en,
  input  wire logic bit_in,
  input  wire logic vld_in,
  input  wire logic pat_bit,
  input  wire logic care_bit,
  output logic      bit_out,
  output logic      vld_out,
  output logic      ok
);

  logic bit_r;
  logic vld_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      bit_r <= bit_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (shift_en) begin
      vld_r <= vld_in;
    end
  end

  assign bit_out = bit_r;
  assign vld_out = vld_r;
  assign ok      = !care_bit || (vld_r && (bit_r == pat_bit));

endmodule
`default_nettype wire

@@ rtl/core/acd_cfg.sv @@
`default_nettype none
// Config registers; keeps the code laid out in history order with a care mask.
module acd_cfg
  import acd_pkg::*;
#(
  parameter int MAX_CODE_BITS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [CODE_W-1:0]        cfg_wdata,
  output logic      [MAX_CODE_BITS-1:0] pattern,
  output logic      [MAX_CODE_BITS-1:0] care
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_BITS);

  logic [MAX_CODE_BITS-1:0] code_r, code_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [MAX_CODE_BITS-1:0] pattern_r, care_r;
  logic [LEN_W-1:0]         alen_nxt;
  logic [LEN_W-1:0]         sh_nxt;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] l);
    logic [LEN_W-1:0] r;
    r = l;
    if (l == '0) r = LEN_W'(1);
    else if (l > MAX_LEN) r = MAX_LEN;
    return r;
  endfunction

  // history bit k holds code bit alen-1-k: reverse, then drop the unused top
  function automatic logic [MAX_CODE_BITS-1:0] code_pattern(
    input logic [MAX_CODE_BITS-1:0] code,
    input logic [LEN_W-1:0]         sh
  );
    logic [MAX_CODE_BITS-1:0] rev;
    for (int i = 0; i < MAX_CODE_BITS; i++) begin
      rev[i] = code[MAX_CODE_BITS-1-i];
    end
    return rev >> sh;
  endfunction

  always_comb begin
    code_nxt = code_r;
    len_nxt  = len_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ACCESS_CODE: code_nxt = cfg_wdata[MAX_CODE_BITS-1:0];
        CFG_CODE_LENGTH: len_nxt  = cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign alen_nxt = clamp_len(len_nxt);
  assign sh_nxt   = MAX_LEN - alen_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r    <= '0;
      len_r     <= CODE_LEN_RESET;
      pattern_r <= '0;
      care_r    <= '1;
    end else begin
      code_r    <= code_nxt;
      len_r     <= len_nxt;
      pattern_r <= code_pattern(code_nxt, sh_nxt);
      care_r    <= {MAX_CODE_BITS{1'b1}} >> sh_nxt;
    end
  end

  assign pattern = pattern_r;
  assign care    = care_r;

endmodule
`default_nettype wire

@@ rtl/core/access_code_header_deframer_core.sv @@
// Match path: the cell row registers the completing bit, then out_valid_r registers the result.
// Throughput: one bit per cycle while in_tready is high; the cell row shifts once per accepted item.
// Input stalls only while a matching item waits behind a result that is not yet taken.
// Reset (synchronous, rst_n low): fill flags cleared, code reset to 0, length to 64;
// no result until code_length + 32 bits have been accepted.
`default_nettype none
`include "assert_macros.svh"
module access_code_header_deframer_core
  import acd_pkg::*;
#(
  parameter int MAX_CODE_BITS = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [0] bit_req, rest zero
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // [15:0] length_first,
                                                  // [31:16] length_second,
                                                  // [32] lengths_agree, rest zero
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [CODE_W-1:0]      cfg_wdata
);

  localparam int CHAIN = MAX_CODE_BITS + HEADER_BITS;

  logic [MAX_CODE_BITS-1:0] pattern, care;
  logic [CHAIN-1:0]         pat_full, care_full;
  logic [CHAIN-1:0]         bit_vec, vld_vec, ok_vec;
  logic [CHAIN-1:0]         bit_src, vld_src;
  logic                     accept, advance, match, out_load;
  logic                     s1_valid_r, s1_valid_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [LEN_BITS-1:0]      first_r, second_r;
  logic                     agree_r;

  acd_cfg #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .pattern   (pattern),
    .care      (care)
  );

  // cells 0..31 are the header (0 newest), the rest the code window
  assign pat_full  = {pattern, {HEADER_BITS{1'b0}}};
  assign care_full = {care, {HEADER_BITS{1'b0}}};
  assign bit_src   = {bit_vec[CHAIN-2:0], in_tdata[0]};
  assign vld_src   = {vld_vec[CHAIN-2:0], 1'b1};

  for (genvar i = 0; i < CHAIN; i++) begin : g_cell
    acd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .bit_in   (bit_src[i]),
      .vld_in   (vld_src[i]),
      .pat_bit  (pat_full[i]),
      .care_bit (care_full[i]),
      .bit_out  (bit_vec[i]),
      .vld_out  (vld_vec[i]),
      .ok       (ok_vec[i])
    );
  end

  assign match    = &ok_vec;
  assign advance  = s1_valid_r && (!match || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign accept   = in_tvalid && in_tready;
  assign out_load = advance && match;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      first_r  <= bit_vec[HEADER_BITS-1:LEN_BITS];
      second_r <= bit_vec[LEN_BITS-1:0];
      agree_r  <= (bit_vec[HEADER_BITS-1:LEN_BITS] == bit_vec[LEN_BITS-1:0]);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2*LEN_BITS - 1){1'b0}}, agree_r, second_r, first_r};

  `ACD_ASSERT_IMP(a_flag_consistent, out_valid_r, agree_r == (first_r == second_r), "bad flag")
  `ACD_ASSERT_IMP(a_fill_thermo, 1'b1, ((vld_vec + CHAIN'(1)) & vld_vec) == '0, "fill gap")
  `ACD_ASSERT_NXT(a_stall_holds, s1_valid_r && !advance, $stable(bit_vec), "moved in stall")
  `ACD_ASSERT_IMP(a_out_from_s1, $rose(out_valid_r), $past(s1_valid_r), "result without item")

endmodule
`default_nettype wire
